FILE: design/ipfc_pkg.sv
// Shared types, register codes and constants for the irrigation pump and fan controller.
`default_nettype none
package ipfc_pkg;

	// field widths
	localparam int RAW_W   = 12;
	localparam int TEMP_W  = 11;
	localparam int PCT_W   = 7;
	localparam int MS_W    = 20;
	localparam int DEB_W   = 16;
	localparam int TIME_W  = 32;
	localparam int LEFT_W  = 11;
	localparam int CFG_A_W = 3;
	localparam int CFG_D_W = 20;
	localparam int IN_W    = 32;
	localparam int OUT_W   = 24;

	// register indexes
	localparam logic [CFG_A_W-1:0] CFG_DRY      = 3'd0;
	localparam logic [CFG_A_W-1:0] CFG_WET      = 3'd1;
	localparam logic [CFG_A_W-1:0] CFG_PUMP_MAX = 3'd2;
	localparam logic [CFG_A_W-1:0] CFG_COOLDOWN = 3'd3;
	localparam logic [CFG_A_W-1:0] CFG_SAMPLE   = 3'd4;
	localparam logic [CFG_A_W-1:0] CFG_DEBOUNCE = 3'd5;
	localparam logic [CFG_A_W-1:0] CFG_FAN_ON   = 3'd6;

	// register reset values
	localparam logic [PCT_W-1:0]  DRY_RST      = 7'd40;
	localparam logic [PCT_W-1:0]  WET_RST      = 7'd70;
	localparam logic [MS_W-1:0]   PUMP_MAX_RST = 20'd15000;
	localparam logic [MS_W-1:0]   COOLDOWN_RST = 20'd30000;
	localparam logic [MS_W-1:0]   SAMPLE_RST   = 20'd2000;
	localparam logic [DEB_W-1:0]  DEBOUNCE_RST = 16'd250;
	localparam logic [TEMP_W-1:0] FAN_ON_RST   = 11'd300;

	// percent = (4095 - raw) * 20 / 519, by reciprocal: ceil(2^27 / 519)
	localparam int               MOIST_X_W   = 17;
	localparam int               MOIST_SHIFT = 27;
	localparam logic [17:0]      MOIST_RECIP = 18'd258609;
	localparam int               QUOT_W      = 8;
	localparam logic [PCT_W-1:0] PCT_MAX     = 7'd100;

	// seconds = ms / 1000, by reciprocal: ceil(2^30 / 1000)
	localparam int          SEC_SHIFT = 30;
	localparam logic [20:0] SEC_RECIP = 21'd1073742;

	typedef struct packed {
		logic [PCT_W-1:0]  dry;
		logic [PCT_W-1:0]  wet;
		logic [MS_W-1:0]   pump_max;
		logic [MS_W-1:0]   cooldown;
		logic [MS_W-1:0]   sample_int;
		logic [DEB_W-1:0]  debounce;
		logic [TEMP_W-1:0] fan_on;
	} cfg_t;

	// control result, before the ms-to-seconds conversion
	typedef struct packed {
		logic             pump_on;
		logic             fan_on;
		logic             safety_lock;
		logic [PCT_W-1:0] moisture_percent;
		logic             sampled;
		logic [MS_W-1:0]  lock_left_ms;
	} ctrl_res_t;

endpackage
`default_nettype wire

FILE: design/irrigation_pump_fan_controller.sv
// Top level: stream ports, configuration registers and the four-stage tick pipeline.
//
//  channel  | direction | signals                          | content
//  ---------+-----------+----------------------------------+-------------------------------
//  s_*      | in        | s_tvalid s_tready s_tdata[31:0]  | one millisecond tick
//  m_*      | out       | m_tvalid m_tready m_tdata[23:0]  | one result per tick
//  cfg_*    | in        | cfg_wen cfg_idx[2:0] cfg_data    | register write, no read-back
//
// One request per cycle while m_tready stays high; four register stages, so m_tvalid rises
// after the input register, percent multiply, control state update and seconds multiply
// stages. The control state loop closes inside the update stage.
// arst_n clears all stage valids and control state and loads register defaults.
// Each stage holds while the next is full and stalled; empty stages collapse.
`default_nettype none
module irrigation_pump_fan_controller (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            s_tvalid,
	output logic                                 s_tready,
	// [11:0] moisture_raw, [22:12] temp_tenths, [23] sensor_valid, [24] button_level
	input  wire logic [ipfc_pkg::IN_W-1:0]       s_tdata,
	output logic                                 m_tvalid,
	input  wire logic                            m_tready,
	// [0] pump_on, [1] fan_on, [2] safety_lock, [9:3] moisture_percent,
	// [20:10] cooldown_left_s, [21] sampled
	output logic [ipfc_pkg::OUT_W-1:0]           m_tdata,
	input  wire logic                            cfg_wen,
	input  wire logic [ipfc_pkg::CFG_A_W-1:0]    cfg_idx,
	input  wire logic [ipfc_pkg::CFG_D_W-1:0]    cfg_data
);
	import ipfc_pkg::*;

	cfg_t cfg_q;

	logic                     v_s1, v_s2, v_s3, out_v_q;
	logic                     adv_s1, adv_s2, adv_s3, adv_out;
	logic [RAW_W-1:0]         raw_s1;
	logic signed [TEMP_W-1:0] temp_s1, temp_s2;
	logic                     valid_s1, valid_s2, button_s1, button_s2;
	logic [QUOT_W-1:0]        quot_s2;
	logic [MOIST_X_W-1:0]     moist_x;
	logic [MOIST_X_W+17:0]    moist_prod;
	ctrl_res_t                res_s3;
	logic [MS_W+20:0]         sec_prod;
	logic [OUT_W-1:0]         out_data_q;

	// stage flow control
	assign adv_out  = !out_v_q || m_tready;
	assign adv_s3   = !v_s3 || adv_out;
	assign adv_s2   = !v_s2 || adv_s3;
	assign adv_s1   = !v_s1 || adv_s2;
	assign s_tready = adv_s1;
	assign m_tvalid = out_v_q;
	assign m_tdata  = out_data_q;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.dry        <= DRY_RST;
			cfg_q.wet        <= WET_RST;
			cfg_q.pump_max   <= PUMP_MAX_RST;
			cfg_q.cooldown   <= COOLDOWN_RST;
			cfg_q.sample_int <= SAMPLE_RST;
			cfg_q.debounce   <= DEBOUNCE_RST;
			cfg_q.fan_on     <= FAN_ON_RST;
		end else if (cfg_wen) begin
			case (cfg_idx)
				CFG_DRY:      cfg_q.dry        <= cfg_data[PCT_W-1:0];
				CFG_WET:      cfg_q.wet        <= cfg_data[PCT_W-1:0];
				CFG_PUMP_MAX: cfg_q.pump_max   <= cfg_data[MS_W-1:0];
				CFG_COOLDOWN: cfg_q.cooldown   <= cfg_data[MS_W-1:0];
				CFG_SAMPLE:   cfg_q.sample_int <= cfg_data[MS_W-1:0];
				CFG_DEBOUNCE: cfg_q.debounce   <= cfg_data[DEB_W-1:0];
				CFG_FAN_ON:   cfg_q.fan_on     <= cfg_data[TEMP_W-1:0];
				default: ;
			endcase
		end
	end

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
			v_s3    <= 1'b0;
			out_v_q <= 1'b0;
		end else begin
			if (adv_s1)
				v_s1 <= s_tvalid;
			if (adv_s2)
				v_s2 <= v_s1;
			if (adv_s3)
				v_s3 <= v_s2;
			if (adv_out)
				out_v_q <= v_s3;
		end
	end

	// stage 1: input register
	always_ff @(posedge clk) begin
		if (adv_s1) begin
			raw_s1    <= s_tdata[RAW_W-1:0];
			temp_s1   <= s_tdata[RAW_W+TEMP_W-1:RAW_W];
			valid_s1  <= s_tdata[RAW_W+TEMP_W];
			button_s1 <= s_tdata[RAW_W+TEMP_W+1];
		end
	end

	// stage 2: (4095 - raw) * 20 times reciprocal of 519
	assign moist_x    = {1'b0, ~raw_s1, 4'b0} + {3'b0, ~raw_s1, 2'b0};
	assign moist_prod = moist_x * MOIST_RECIP;

	always_ff @(posedge clk) begin
		if (adv_s2) begin
			quot_s2   <= moist_prod[MOIST_SHIFT+QUOT_W-1:MOIST_SHIFT];
			temp_s2   <= temp_s1;
			valid_s2  <= valid_s1;
			button_s2 <= button_s1;
		end
	end

	// stage 3: control state update
	ipfc_core u_core (
		.clk          (clk),
		.arst_n       (arst_n),
		.step         (adv_s3 && v_s2),
		.cfg          (cfg_q),
		.quot         (quot_s2),
		.temp_tenths  (temp_s2),
		.sensor_valid (valid_s2),
		.button_level (button_s2),
		.res          (res_s3)
	);

	// output stage: lockout ms to whole seconds
	assign sec_prod = res_s3.lock_left_ms * SEC_RECIP;

	always_ff @(posedge clk) begin
		if (adv_out) begin
			out_data_q <= {2'b0, res_s3.sampled,
				sec_prod[SEC_SHIFT+LEFT_W-1:SEC_SHIFT],
				res_s3.moisture_percent, res_s3.safety_lock,
				res_s3.fan_on, res_s3.pump_on};
		end
	end

	// pump never runs while locked out
	a_pump_lock: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !(m_tdata[0] && m_tdata[2]))
		else $error("pump on during lockout");

	// remaining cooldown only reported while locked
	a_left_lock: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && (m_tdata[20:10] != '0)) |-> m_tdata[2])
		else $error("cooldown left without lockout");

	// percent saturates at 100
	a_pct_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[9:3] <= PCT_MAX))
		else $error("moisture percent above 100");

endmodule
`default_nettype wire

FILE: design/ipfc_core.sv
// Control state machine: button toggle, pump run limit, lockout and sampling, one tick per step.
`default_nettype none
module ipfc_core (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          step,
	input  wire ipfc_pkg::cfg_t                cfg,
	input  wire logic [ipfc_pkg::QUOT_W-1:0]   quot,
	input  wire logic signed [ipfc_pkg::TEMP_W-1:0] temp_tenths,
	input  wire logic                          sensor_valid,
	input  wire logic                          button_level,
	output ipfc_pkg::ctrl_res_t                res
);
	import ipfc_pkg::*;

	logic [TIME_W-1:0] now_q, last_samp_q, last_tog_q, pump_start_q, lock_start_q;
	logic              button_prev_q, pump_q, fan_q, lock_q;
	logic [PCT_W-1:0]  moist_q;
	ctrl_res_t         res_q;

	logic [PCT_W-1:0]  pct;
	logic [TIME_W-1:0] el_lock;
	logic              tog, forced, expire, samp;
	logic              pump1, lock1, lock2;
	logic              pump_n, lock_n, fan_n;
	logic [TIME_W-1:0] pump_start_n;
	logic [MS_W-1:0]   left_ms;

	// saturate the calibrated percent
	assign pct = (quot > {1'b0, PCT_MAX}) ? PCT_MAX : quot[PCT_W-1:0];

	// next-state logic, all timer differences from the old state
	always_comb begin
		tog = !button_level && button_prev_q &&
			((now_q - last_tog_q) > {{(TIME_W-DEB_W){1'b0}}, cfg.debounce});
		forced = pump_q && ((now_q - pump_start_q) >= {{(TIME_W-MS_W){1'b0}}, cfg.pump_max});
		pump1 = pump_q && !forced;
		lock1 = lock_q || forced;
		el_lock = forced ? '0 : (now_q - lock_start_q);
		expire = lock1 && (el_lock >= {{(TIME_W-MS_W){1'b0}}, cfg.cooldown});
		lock2 = lock1 && !expire;
		samp = (now_q - last_samp_q) >= {{(TIME_W-MS_W){1'b0}}, cfg.sample_int};

		pump_n = pump1;
		lock_n = lock2;
		fan_n = fan_q ^ tog;
		pump_start_n = pump_start_q;
		if (samp && sensor_valid) begin
			if (pct < cfg.dry) begin
				if (!lock2 && !pump1) begin
					pump_n = 1'b1;
					pump_start_n = now_q;
				end
			end else if (pct > cfg.wet) begin
				pump_n = 1'b0;
				lock_n = 1'b0;
			end else begin
				lock_n = 1'b0;
			end
			fan_n = $signed(temp_tenths) > $signed(cfg.fan_on);
		end

		// remaining lockout in ms; lock start is not moved by the sample
		if (lock_n && (el_lock < {{(TIME_W-MS_W){1'b0}}, cfg.cooldown}))
			left_ms = cfg.cooldown - el_lock[MS_W-1:0];
		else
			left_ms = '0;
	end

	// state and result registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			now_q         <= '0;
			last_samp_q   <= '0;
			last_tog_q    <= '0;
			pump_start_q  <= '0;
			lock_start_q  <= '0;
			button_prev_q <= 1'b1;
			pump_q        <= 1'b0;
			fan_q         <= 1'b0;
			lock_q        <= 1'b0;
			moist_q       <= '0;
			res_q         <= '0;
		end else if (step) begin
			now_q         <= now_q + TIME_W'(1);
			button_prev_q <= button_level;
			if (tog)
				last_tog_q <= now_q;
			if (forced)
				lock_start_q <= now_q;
			if (samp) begin
				last_samp_q <= now_q;
				moist_q     <= pct;
			end
			pump_start_q <= pump_start_n;
			pump_q       <= pump_n;
			fan_q        <= fan_n;
			lock_q       <= lock_n;
			res_q.pump_on          <= pump_n;
			res_q.fan_on           <= fan_n;
			res_q.safety_lock      <= lock_n;
			res_q.moisture_percent <= samp ? pct : moist_q;
			res_q.sampled          <= samp;
			res_q.lock_left_ms     <= left_ms;
		end
	end

	assign res = res_q;

endmodule
`default_nettype wire

FILE: sim/tb_irrigation_pump_fan_controller.sv
// Self-checking testbench for the irrigation pump and fan controller.
module tb_irrigation_pump_fan_controller;
	import ipfc_pkg::*;

	localparam int STALL_LIMIT  = 2000;
	localparam int ADC_AIR      = 4095;
	localparam int ADC_SPAN     = 2595;
	localparam int MS_PER_SEC   = 1000;
	localparam int END_SETTLE   = 8;
	localparam int SHOW_LIMIT   = 10;

	// one millisecond tick, fields listed from the highest bit down
	typedef struct packed {
		logic              button_level;
		logic              sensor_valid;
		logic [TEMP_W-1:0] temp_tenths;
		logic [RAW_W-1:0]  moisture_raw;
	} tick_t;

	// relay status after one tick, fields listed from the highest bit down
	typedef struct packed {
		logic              sampled;
		logic [LEFT_W-1:0] cooldown_left_s;
		logic [PCT_W-1:0]  moisture_percent;
		logic              safety_lock;
		logic              fan_on;
		logic              pump_on;
	} status_t;

	// directed table row: a register write or a tick, optionally with typed status
	typedef struct packed {
		logic               is_cfg;
		logic [CFG_A_W-1:0] idx;
		logic [CFG_D_W-1:0] data;
		tick_t              tk;
		logic               has_exp;
		status_t            want;
	} row_t;

	typedef enum int {PROF_RANDOM, PROF_ZERO, PROF_MAX, PROF_DEFAULT} profile_e;

	logic                clk;
	logic                arst_n;
	logic                s_tvalid;
	logic                s_tready;
	logic [IN_W-1:0]     s_tdata;
	logic                m_tvalid;
	logic                m_tready;
	logic [OUT_W-1:0]    m_tdata;
	logic                cfg_wen;
	logic [CFG_A_W-1:0]  cfg_idx;
	logic [CFG_D_W-1:0]  cfg_data;

	// shadow of the controller state
	cfg_t               relay_cfg;
	logic [TIME_W-1:0]  ms_now, ms_last_sample, ms_last_toggle, ms_pump_start, ms_lock_start;
	logic               btn_prev, pump_st, fan_st, lock_st;
	logic [PCT_W-1:0]   pct_last;

	status_t status_q[$];
	logic    btn_level;
	logic    tx_calm, rx_calm;
	int      n_fail, n_checked, n_ticks;
	int      n_samples, n_pump_starts, n_lockouts, n_toggles;
	int      idle_cycles;

	irrigation_pump_fan_controller uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.cfg_wen  (cfg_wen),
		.cfg_idx  (cfg_idx),
		.cfg_data (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// register update of the shadow copy
	function automatic void store_reg(input logic [CFG_A_W-1:0] idx, input logic [CFG_D_W-1:0] d);
		case (idx)
			CFG_DRY:      relay_cfg.dry        = d[PCT_W-1:0];
			CFG_WET:      relay_cfg.wet        = d[PCT_W-1:0];
			CFG_PUMP_MAX: relay_cfg.pump_max   = d[MS_W-1:0];
			CFG_COOLDOWN: relay_cfg.cooldown   = d[MS_W-1:0];
			CFG_SAMPLE:   relay_cfg.sample_int = d[MS_W-1:0];
			CFG_DEBOUNCE: relay_cfg.debounce   = d[DEB_W-1:0];
			CFG_FAN_ON:   relay_cfg.fan_on     = d[TEMP_W-1:0];
			default: ;
		endcase
	endfunction

	// expected relay status for one tick; advances the shadow state
	function automatic status_t advance_ms_tick(input tick_t tk);
		status_t r;
		logic [TIME_W-1:0] t;
		logic [TIME_W-1:0] held;
		int unsigned pct;
		r = '0;
		t = ms_now;
		// manual fan toggle on a falling edge outside the debounce window
		if (!tk.button_level && btn_prev && (t - ms_last_toggle) > 32'(relay_cfg.debounce)) begin
			ms_last_toggle = t;
			fan_st = !fan_st;
			n_toggles++;
		end
		btn_prev = tk.button_level;
		// run-time limit: force off and lock out
		if (pump_st && (t - ms_pump_start) >= 32'(relay_cfg.pump_max)) begin
			pump_st = 1'b0;
			lock_st = 1'b1;
			ms_lock_start = t;
			n_lockouts++;
		end
		if (lock_st && (t - ms_lock_start) >= 32'(relay_cfg.cooldown))
			lock_st = 1'b0;
		// control sample
		if ((t - ms_last_sample) >= 32'(relay_cfg.sample_int)) begin
			ms_last_sample = t;
			r.sampled = 1'b1;
			n_samples++;
			pct = (ADC_AIR - 32'(tk.moisture_raw)) * 100 / ADC_SPAN;
			pct_last = (pct > 100) ? PCT_MAX : PCT_W'(pct);
			if (tk.sensor_valid) begin
				if (pct_last < relay_cfg.dry) begin
					if (!lock_st && !pump_st) begin
						pump_st = 1'b1;
						ms_pump_start = t;
						n_pump_starts++;
					end
				end else if (pct_last > relay_cfg.wet) begin
					pump_st = 1'b0;
					lock_st = 1'b0;
				end else begin
					lock_st = 1'b0;
				end
				fan_st = $signed(tk.temp_tenths) > $signed(relay_cfg.fan_on);
			end
		end
		if (lock_st) begin
			held = t - ms_lock_start;
			if (held < 32'(relay_cfg.cooldown))
				r.cooldown_left_s = LEFT_W'((32'(relay_cfg.cooldown) - held) / MS_PER_SEC);
		end
		r.pump_on          = pump_st;
		r.fan_on           = fan_st;
		r.safety_lock      = lock_st;
		r.moisture_percent = pct_last;
		ms_now = t + 1;
		return r;
	endfunction

	function automatic tick_t make_tick(input int raw, input int temp, input bit valid,
			input bit btn);
		tick_t tk;
		tk.moisture_raw = RAW_W'(raw);
		tk.temp_tenths  = TEMP_W'(temp);
		tk.sensor_valid = valid;
		tk.button_level = btn;
		return tk;
	endfunction

	function automatic row_t tick_row(input int raw, input int temp, input bit valid,
			input bit btn);
		row_t rw;
		rw = '0;
		rw.tk = make_tick(raw, temp, valid, btn);
		return rw;
	endfunction

	function automatic row_t cfg_row(input logic [CFG_A_W-1:0] idx, input logic [CFG_D_W-1:0] d);
		row_t rw;
		rw = '0;
		rw.is_cfg = 1'b1;
		rw.idx = idx;
		rw.data = d;
		return rw;
	endfunction

	function automatic row_t with_status(input row_t rw, input bit pump, input bit fan,
			input bit lock, input int pct, input int left, input bit smp);
		rw.has_exp = 1'b1;
		rw.want.pump_on = pump;
		rw.want.fan_on = fan;
		rw.want.safety_lock = lock;
		rw.want.moisture_percent = PCT_W'(pct);
		rw.want.cooldown_left_s = LEFT_W'(left);
		rw.want.sampled = smp;
		return rw;
	endfunction

	// random tick, biased toward the moisture and temperature thresholds
	function automatic tick_t draw_tick();
		int pick, target, raw, temp;
		pick = $urandom_range(0, 9);
		if (pick < 4) begin
			raw = $urandom_range(0, 4095);
		end else begin
			target = (pick < 7) ? int'(relay_cfg.dry) : int'(relay_cfg.wet);
			raw = ADC_AIR - target * ADC_SPAN / 100 + int'($urandom_range(0, 80)) - 40;
			if (raw < 0) raw = 0;
			if (raw > 4095) raw = 4095;
		end
		pick = $urandom_range(0, 9);
		if (pick < 5)
			temp = int'($signed(relay_cfg.fan_on)) + int'($urandom_range(0, 40)) - 20;
		else if (pick < 8)
			temp = int'($urandom_range(0, 1200)) - 400;
		else
			temp = int'($urandom_range(0, 2047)) - 1024;
		if (temp < -1024) temp = -1024;
		if (temp > 1023) temp = 1023;
		if ($urandom_range(0, 3) == 0)
			btn_level = ~btn_level;
		return make_tick(raw, temp, $urandom_range(0, 9) != 0, btn_level);
	endfunction

	// one tick request; prediction taken at the accepting edge
	task automatic send_tick(input tick_t tk, input logic has_exp, input status_t typed);
		int gap;
		status_t pred;
		gap = tx_calm ? 0 : $urandom_range(0, 5);
		repeat (gap) begin
			@(negedge clk);
			s_tvalid <= 1'b0;
		end
		@(negedge clk);
		s_tvalid <= 1'b1;
		s_tdata <= {{(IN_W - $bits(tick_t)){1'b0}}, tk};
		do @(posedge clk); while (!s_tready);
		pred = advance_ms_tick(tk);
		status_q.push_back(has_exp ? typed : pred);
		n_ticks++;
	endtask

	// stop sending and wait for every outstanding status
	task automatic drain_block();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (status_q.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_A_W-1:0] idx, input logic [CFG_D_W-1:0] d);
		@(negedge clk);
		cfg_wen <= 1'b1;
		cfg_idx <= idx;
		cfg_data <= d;
		@(negedge clk);
		cfg_wen <= 1'b0;
		store_reg(idx, d);
	endtask

	task automatic run_phase(input profile_e prof, input int count);
		logic [CFG_D_W-1:0] val [7];
		int dry;
		int wet;
		drain_block();
		case (prof)
			PROF_ZERO: begin
				foreach (val[i]) val[i] = '0;
				val[CFG_FAN_ON] = CFG_D_W'(TEMP_W'(-1024));
			end
			PROF_MAX: begin
				val[CFG_DRY]      = CFG_D_W'(7'h7F);
				val[CFG_WET]      = CFG_D_W'(7'h7F);
				val[CFG_PUMP_MAX] = 20'hFFFFF;
				val[CFG_COOLDOWN] = 20'hFFFFF;
				val[CFG_SAMPLE]   = 20'hFFFFF;
				val[CFG_DEBOUNCE] = CFG_D_W'(16'hFFFF);
				val[CFG_FAN_ON]   = CFG_D_W'(TEMP_W'(1023));
			end
			PROF_DEFAULT: begin
				val[CFG_DRY]      = CFG_D_W'(DRY_RST);
				val[CFG_WET]      = CFG_D_W'(WET_RST);
				val[CFG_PUMP_MAX] = CFG_D_W'(PUMP_MAX_RST);
				val[CFG_COOLDOWN] = CFG_D_W'(COOLDOWN_RST);
				val[CFG_SAMPLE]   = CFG_D_W'(SAMPLE_RST);
				val[CFG_DEBOUNCE] = CFG_D_W'(DEBOUNCE_RST);
				val[CFG_FAN_ON]   = CFG_D_W'(FAN_ON_RST);
			end
			default: begin
				// short timings so that pump runs, lockouts and toggles recur
				dry = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 127) : $urandom_range(20, 70);
				wet = dry + $urandom_range(0, 40);
				if (wet > 127) wet = 127;
				val[CFG_DRY]      = CFG_D_W'(dry);
				val[CFG_WET]      = CFG_D_W'(wet);
				val[CFG_PUMP_MAX] = CFG_D_W'($urandom_range(0, 60));
				val[CFG_COOLDOWN] = $urandom_range(0, 1) ? CFG_D_W'($urandom_range(0, 40))
				                                         : CFG_D_W'($urandom_range(1000, 4000));
				val[CFG_SAMPLE]   = CFG_D_W'($urandom_range(0, 6));
				val[CFG_DEBOUNCE] = CFG_D_W'($urandom_range(0, 20));
				val[CFG_FAN_ON]   = CFG_D_W'(TEMP_W'(int'($urandom_range(0, 1200)) - 400));
			end
		endcase
		foreach (val[i])
			write_reg(CFG_A_W'(i), val[i]);
		tx_calm = ($urandom_range(0, 3) == 0);
		rx_calm = ($urandom_range(0, 3) == 0);
		for (int n = 0; n < count; n++) begin
			send_tick(draw_tick(), 1'b0, '0);
			if ($urandom_range(0, 149) == 0)
				drain_block();
			if ($urandom_range(0, 59) == 0)
				tx_calm = ~tx_calm;
			if ($urandom_range(0, 59) == 0)
				rx_calm = ~rx_calm;
		end
	endtask

	task automatic compare_status(input status_t want, input status_t got);
		string bad;
		bad = "";
		if (got.pump_on !== want.pump_on) bad = {bad, " pump_on"};
		if (got.fan_on !== want.fan_on) bad = {bad, " fan_on"};
		if (got.safety_lock !== want.safety_lock) bad = {bad, " safety_lock"};
		if (got.moisture_percent !== want.moisture_percent) bad = {bad, " moisture_percent"};
		if (got.cooldown_left_s !== want.cooldown_left_s) bad = {bad, " cooldown_left_s"};
		if (got.sampled !== want.sampled) bad = {bad, " sampled"};
		n_checked++;
		if (bad != "") begin
			n_fail++;
			if (n_fail <= SHOW_LIMIT)
				$display("status %0d wrong:%s | exp pump=%0b fan=%0b lock=%0b pct=%0d left=%0d smp=%0b | got pump=%0b fan=%0b lock=%0b pct=%0d left=%0d smp=%0b",
					n_checked, bad, want.pump_on, want.fan_on, want.safety_lock,
					want.moisture_percent, want.cooldown_left_s, want.sampled,
					got.pump_on, got.fan_on, got.safety_lock, got.moisture_percent,
					got.cooldown_left_s, got.sampled);
		end
	endtask

	// result side: random stalls, each status checked against the oldest expected one
	initial begin : status_monitor
		int stall;
		status_t got;
		@(posedge arst_n);
		forever begin
			stall = rx_calm ? 0 : $urandom_range(0, 5);
			repeat (stall) begin
				@(negedge clk);
				m_tready <= 1'b0;
			end
			@(negedge clk);
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
			got = status_t'(m_tdata[$bits(status_t)-1:0]);
			if (status_q.size() == 0) begin
				n_fail++;
				if (n_fail <= SHOW_LIMIT)
					$display("status with no tick outstanding: %h", m_tdata);
			end else begin
				compare_status(status_q.pop_front(), got);
			end
		end
	end

	// watchdog on cycles with no request moving
	always @(posedge clk) begin
		if (!arst_n) begin
			idle_cycles <= 0;
		end else if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= STALL_LIMIT) begin
			$display("no request moved for %0d cycles", STALL_LIMIT);
			$display("status: fail");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin : main_flow
		row_t plan[$];
		s_tvalid = 1'b0;
		s_tdata  = '0;
		m_tready = 1'b0;
		cfg_wen  = 1'b0;
		cfg_idx  = '0;
		cfg_data = '0;
		arst_n   = 1'b0;
		idle_cycles = 0;
		n_fail = 0; n_checked = 0; n_ticks = 0;
		n_samples = 0; n_pump_starts = 0; n_lockouts = 0; n_toggles = 0;
		tx_calm = 1'b0;
		rx_calm = 1'b0;
		btn_level = 1'b1;

		// shadow state at reset
		relay_cfg = '{dry: DRY_RST, wet: WET_RST, pump_max: PUMP_MAX_RST,
			cooldown: COOLDOWN_RST, sample_int: SAMPLE_RST, debounce: DEBOUNCE_RST,
			fan_on: FAN_ON_RST};
		ms_now = '0; ms_last_sample = '0; ms_last_toggle = '0;
		ms_pump_start = '0; ms_lock_start = '0;
		btn_prev = 1'b1; pump_st = 1'b0; fan_st = 1'b0; lock_st = 1'b0;
		pct_last = '0;

		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed: reset state, every tick a sample, zero run time and cooldown,
		// saturated moisture, invalid data, debounce of zero, longest lockout,
		// thresholds outside the calibrated range
		plan.push_back(with_status(tick_row(0, -1024, 1, 1), 0, 0, 0, 0, 0, 0));
		plan.push_back(cfg_row(CFG_SAMPLE, '0));
		plan.push_back(with_status(tick_row(4095, 1023, 1, 1), 1, 1, 0, 0, 0, 1));
		plan.push_back(cfg_row(CFG_PUMP_MAX, '0));
		plan.push_back(cfg_row(CFG_COOLDOWN, '0));
		plan.push_back(tick_row(4095, 0, 1, 1));
		plan.push_back(with_status(tick_row(0, 0, 1, 1), 0, 0, 0, 100, 0, 1));
		plan.push_back(tick_row(1500, 300, 1, 1));
		plan.push_back(tick_row(1501, 301, 0, 0));
		plan.push_back(cfg_row(CFG_DEBOUNCE, '0));
		plan.push_back(tick_row(4000, 500, 0, 1));
		plan.push_back(tick_row(4000, 500, 0, 0));
		plan.push_back(tick_row(3000, -400, 0, 1));
		plan.push_back(tick_row(3000, 800, 0, 0));
		plan.push_back(cfg_row(CFG_PUMP_MAX, CFG_D_W'(1)));
		plan.push_back(cfg_row(CFG_COOLDOWN, 20'hFFFFF));
		plan.push_back(tick_row(4095, 0, 1, 1));
		plan.push_back(with_status(tick_row(4095, 0, 1, 1), 0, 0, 1, 0, 1048, 1));
		plan.push_back(tick_row(2500, 0, 1, 1));
		plan.push_back(cfg_row(CFG_DRY, CFG_D_W'(7'h7F)));
		plan.push_back(cfg_row(CFG_WET, CFG_D_W'(7'h7F)));
		plan.push_back(cfg_row(CFG_FAN_ON, CFG_D_W'(TEMP_W'(-1024))));
		plan.push_back(tick_row(0, -1023, 1, 0));
		plan.push_back(cfg_row(CFG_FAN_ON, CFG_D_W'(TEMP_W'(1023))));
		plan.push_back(tick_row(4095, 1023, 1, 1));

		foreach (plan[i]) begin
			if (plan[i].is_cfg) begin
				drain_block();
				write_reg(plan[i].idx, plan[i].data);
			end else begin
				send_tick(plan[i].tk, plan[i].has_exp, plan[i].want);
			end
		end

		// random phases, extremes among them
		run_phase(PROF_RANDOM, 250);
		run_phase(PROF_ZERO, 200);
		run_phase(PROF_RANDOM, 250);
		run_phase(PROF_MAX, 150);
		run_phase(PROF_RANDOM, 250);
		run_phase(PROF_RANDOM, 250);
		run_phase(PROF_DEFAULT, 150);
		run_phase(PROF_RANDOM, 250);
		run_phase(PROF_RANDOM, 250);

		drain_block();
		repeat (END_SETTLE) @(posedge clk);

		$display("ran %0d ticks, checked %0d status words, %0d mismatches", n_ticks, n_checked,
			n_fail);
		$display("seen: %0d sample ticks, %0d pump starts, %0d forced stops, %0d fan toggles",
			n_samples, n_pump_starts, n_lockouts, n_toggles);
		if (n_fail == 0 && status_q.size() == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
